// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Sizes, request and status codes, entry layout and the ring-address helper.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH      = 16;
  localparam int TAG_BITS   = 16;
  localparam int LEVEL_BITS = 4;

  // Slot index into storage, and fill count that can hold DEPTH itself
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = ((LEVEL_BITS + TAG_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((TAG_BITS + LEVEL_BITS + 1 + 7) / 8) * 8;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic [TAG_BITS-1:0]   tag;
  } entry_t;

  // Storage port request from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  // Finished result handed to the output register
  typedef struct packed {
    logic                  valid;
    status_e               status;
    logic [TAG_BITS-1:0]   tag;
    logic [LEVEL_BITS-1:0] level;
    logic                  empty;
  } rsp_t;

  // Physical slot of logical position ofs behind the ring head
  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] head,
                                                logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, ofs};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== sv/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl: sequencer for the stable priority queue
// Keeps the sorted entries in a ring; an enqueue walks back from the tail,
// moving each entry with a higher level up one slot through one shared
// comparator, then drops the new entry into the gap.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  cmd_e                  req_cmd_i,
  input  logic [LEVEL_BITS-1:0] req_level_i,
  input  logic [TAG_BITS-1:0]   req_tag_i,
  output rsp_t                  rsp_o,
  input  logic                  rsp_ready_i,
  output ram_req_t              ram_o,
  input  entry_t                ram_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_CMP,
    S_INS,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [IDX_W-1:0]      head_q;
  logic [CNT_W-1:0]      count_q;
  logic [IDX_W-1:0]      idx_q;
  logic [LEVEL_BITS-1:0] lvl_q;
  logic [TAG_BITS-1:0]   tag_q;
  status_e               res_status_q;
  logic [TAG_BITS-1:0]   res_tag_q;
  logic [LEVEL_BITS-1:0] res_level_q;

  logic                  accept;
  logic                  is_empty;
  logic                  is_full;
  logic                  move_up;
  logic [IDX_W-1:0]      rd_ofs;
  entry_t                new_entry;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign is_empty    = (count_q == '0);
  assign is_full     = (count_q == CNT_W'(DEPTH));

  // Shared comparator: stored entry ranks after the new one
  assign move_up = (ram_rdata_i.level > lvl_q);

  // Drive storage port
  always_comb begin
    if (state_q == S_IDLE) begin
      rd_ofs = (req_cmd_i == CMD_DEQ) ? '0 : IDX_W'(count_q - 1'b1);
      new_entry.level = req_level_i;
      new_entry.tag   = req_tag_i;
    end else begin
      rd_ofs = IDX_W'(idx_q - 1'b1);
      new_entry.level = lvl_q;
      new_entry.tag   = tag_q;
    end
    ram_o.raddr = wrap_add(head_q, rd_ofs);
    ram_o.we    = 1'b0;
    ram_o.waddr = head_q;
    ram_o.wdata = new_entry;
    case (state_q)
      S_IDLE: begin
        ram_o.we = accept && (req_cmd_i == CMD_ENQ) && is_empty;
      end
      S_CMP: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = wrap_add(head_q, IDX_W'(idx_q + 1'b1));
        ram_o.wdata = move_up ? ram_rdata_i : new_entry;
      end
      S_INS: begin
        ram_o.we = 1'b1;
      end
      default: begin
        ram_o.we = 1'b0;
      end
    endcase
  end

  // Sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      lvl_q        <= '0;
      tag_q        <= '0;
      res_status_q <= ST_DONE;
      res_tag_q    <= '0;
      res_level_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            lvl_q        <= req_level_i;
            tag_q        <= req_tag_i;
            res_status_q <= ST_DONE;
            res_tag_q    <= '0;
            res_level_q  <= '0;
            if (req_cmd_i == CMD_DEQ) begin
              if (is_empty) begin
                res_status_q <= ST_EMPTY;
                state_q      <= S_DONE;
              end else begin
                state_q <= S_DEQ;
              end
            end else if (is_full) begin
              res_status_q <= ST_FULL;
              state_q      <= S_DONE;
            end else if (is_empty) begin
              count_q <= count_q + 1'b1;
              state_q <= S_DONE;
            end else begin
              idx_q   <= IDX_W'(count_q - 1'b1);
              state_q <= S_CMP;
            end
          end
        end
        S_DEQ: begin
          // Front entry is on the read port; advance the head
          res_tag_q   <= ram_rdata_i.tag;
          res_level_q <= ram_rdata_i.level;
          head_q      <= wrap_add(head_q, IDX_W'(1));
          count_q     <= count_q - 1'b1;
          state_q     <= S_DONE;
        end
        S_CMP: begin
          if (move_up) begin
            if (idx_q == '0) begin
              state_q <= S_INS;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end else begin
            count_q <= count_q + 1'b1;
            state_q <= S_DONE;
          end
        end
        S_INS: begin
          count_q <= count_q + 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (rsp_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid  = (state_q == S_DONE);
  assign rsp_o.status = res_status_q;
  assign rsp_o.tag    = res_tag_q;
  assign rsp_o.level  = res_level_q;
  assign rsp_o.empty  = is_empty;

endmodule

// ===== sv/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded stable priority queue
// Lower level served first, equal levels in arrival order; one result per
// request.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                 | tuser
//  s_axis   | in  | level, tag                         | cmd
//  m_axis   | out | out_tag, out_level, is_empty       | status
//
//  An enqueue walks back one slot per cycle through the level comparator
//  and the storage read port; a dequeue reads the front entry and advances
//  the head; full or empty requests go straight to their result. Reset clears
//  the fill count and ring head only; storage needs no clearing pass. A new
//  request is taken once the previous result has moved to the output register,
//  which holds it while m_axis stalls.
// ----------------------------------------------------------------------------
module stable_priority_queue
  import spq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // level, tag
  input  logic                  s_axis_tuser,   // cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_tag, out_level, is_empty
  output logic [1:0]            m_axis_tuser    // status
);

  rsp_t     rsp;
  logic     rsp_ready;
  ram_req_t ram_req;
  entry_t   ram_rdata;
  cmd_e     req_cmd;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [TAG_BITS-1:0]   out_tag_q;
  logic [LEVEL_BITS-1:0] out_level_q;
  logic                  out_empty_q;

  assign req_cmd = cmd_e'(s_axis_tuser);

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_cmd_i   (req_cmd),
    .req_level_i (s_axis_tdata[LEVEL_BITS-1:0]),
    .req_tag_i   (s_axis_tdata[LEVEL_BITS+TAG_BITS-1:LEVEL_BITS]),
    .rsp_o       (rsp),
    .rsp_ready_i (rsp_ready),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  spq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: load when empty or being drained
  assign rsp_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp.valid) begin
      out_status_q <= rsp.status;
      out_tag_q    <= rsp.tag;
      out_level_q  <= rsp.level;
      out_empty_q  <= rsp.empty;
    end
  end

  // Pack result fields
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[TAG_BITS-1:0]                   = out_tag_q;
    m_axis_tdata[TAG_BITS+LEVEL_BITS-1:TAG_BITS] = out_level_q;
    m_axis_tdata[TAG_BITS+LEVEL_BITS]            = out_empty_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;

`ifndef SYNTH
  // Sequencer keeps its result until the output register takes it
  a_rsp_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp_ready |=> rsp.valid)
    else $error("result dropped before transfer");

  // No new request while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !rsp.valid)
    else $error("request taken with result pending");

  // A dequeue on empty returns nothing and reports empty
  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status == ST_EMPTY |-> rsp.empty && rsp.tag == '0
                                            && rsp.level == '0)
    else $error("empty status with payload");

  // A dropped enqueue can only happen on a full queue
  a_full_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status == ST_FULL |-> !rsp.empty)
    else $error("full status on empty queue");
`endif

endmodule

// ===== test/stable_priority_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: self-checking bench for the stable priority queue
// A short directed table covers empty and full queues, level extremes and
// tie ordering. Random phases with varied enqueue mix and level spread follow.
// Every result is checked against the table's expected result or an in-bench sorted-array predictor.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int ITEM_TARGET = 1050;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 2 * DEPTH + 4;

  typedef struct packed {
    status_e               status;
    logic [TAG_BITS-1:0]   tag;
    logic [LEVEL_BITS-1:0] level;
    logic                  empty;
  } qresult_t;

  // One directed row; repeated rows step the tag and flip level bits
  typedef struct packed {
    cmd_e                  cmd;
    logic [LEVEL_BITS-1:0] level;
    logic [TAG_BITS-1:0]   tag;
    logic [4:0]            reps;
    logic                  typed;
    qresult_t              want;
  } script_row_t;

  localparam int SCRIPT_ROWS = 19;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // empty after reset, then both level extremes and tag extremes
    '{CMD_DEQ, 4'd0,  16'h0000, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 4'd0,  1'b1}},
    '{CMD_ENQ, 4'd15, 16'hFFFF, 5'd1,  1'b1, '{ST_DONE,  16'h0000, 4'd0,  1'b0}},
    '{CMD_ENQ, 4'd0,  16'h0000, 5'd1,  1'b1, '{ST_DONE,  16'h0000, 4'd0,  1'b0}},
    '{CMD_DEQ, 4'd0,  16'h0000, 5'd1,  1'b1, '{ST_DONE,  16'h0000, 4'd0,  1'b0}},
    '{CMD_DEQ, 4'd0,  16'h0000, 5'd1,  1'b1, '{ST_DONE,  16'hFFFF, 4'd15, 1'b1}},
    '{CMD_DEQ, 4'd0,  16'h0000, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 4'd0,  1'b1}},
    // ties keep arrival order, lower levels jump ahead
    '{CMD_ENQ, 4'd5,  16'h1111, 5'd1,  1'b0, '0},
    '{CMD_ENQ, 4'd5,  16'h2222, 5'd1,  1'b0, '0},
    '{CMD_ENQ, 4'd3,  16'hAAAA, 5'd1,  1'b0, '0},
    '{CMD_ENQ, 4'd5,  16'h3333, 5'd1,  1'b0, '0},
    '{CMD_ENQ, 4'd15, 16'h5555, 5'd1,  1'b0, '0},
    '{CMD_ENQ, 4'd0,  16'h6666, 5'd1,  1'b0, '0},
    '{CMD_DEQ, 4'd0,  16'h0000, 5'd6,  1'b0, '0},
    '{CMD_DEQ, 4'd0,  16'h0000, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 4'd0,  1'b1}},
    // fill to capacity with every level, then overflow
    '{CMD_ENQ, 4'd9,  16'h8000, 5'd16, 1'b0, '0},
    '{CMD_ENQ, 4'd0,  16'h1234, 5'd1,  1'b1, '{ST_FULL,  16'h0000, 4'd0,  1'b0}},
    '{CMD_ENQ, 4'd15, 16'hFFFF, 5'd1,  1'b1, '{ST_FULL,  16'h0000, 4'd0,  1'b0}},
    '{CMD_DEQ, 4'd0,  16'h0000, 5'd16, 1'b0, '0},
    '{CMD_DEQ, 4'd0,  16'h0000, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 4'd0,  1'b1}}
  };

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // level, tag
  logic                  s_axis_tuser  = 1'b0;  // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;          // out_tag, out_level, is_empty
  logic [1:0]            m_axis_tuser;          // status

  // Predictor state: sorted storage, front at slot 0
  logic [LEVEL_BITS-1:0] held_levels [DEPTH];
  logic [TAG_BITS-1:0]   held_tags   [DEPTH];
  int                    held_count  = 0;

  qresult_t pending_results [$];
  int       sent_count  = 0;
  int       error_count = 0;
  int       idle_cycles = 0;
  logic     steady      = 1'b0;

  stable_priority_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one request to the sorted array and return its result
  function automatic qresult_t apply_request(cmd_e cmd, logic [LEVEL_BITS-1:0] lv,
                                             logic [TAG_BITS-1:0] tg);
    qresult_t res;
    int       slot;
    int       i;
    res = '{status: ST_DONE, tag: '0, level: '0, empty: 1'b0};
    if (cmd == CMD_ENQ) begin
      if (held_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        slot = 0;
        while (slot < held_count && held_levels[slot] <= lv) slot++;
        for (i = held_count; i > slot; i--) begin
          held_levels[i] = held_levels[i-1];
          held_tags[i]   = held_tags[i-1];
        end
        held_levels[slot] = lv;
        held_tags[slot]   = tg;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.tag   = held_tags[0];
      res.level = held_levels[0];
      for (i = 1; i < held_count; i++) begin
        held_levels[i-1] = held_levels[i];
        held_tags[i-1]   = held_tags[i];
      end
      held_count--;
    end
    res.empty = (held_count == 0);
    return res;
  endfunction

  // Present one request, hold it until taken, then record what it must return
  task automatic send_request(input cmd_e cmd, input logic [LEVEL_BITS-1:0] lv,
                              input logic [TAG_BITS-1:0] tg, input logic typed,
                              input qresult_t want);
    int       gap;
    qresult_t predicted;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({tg, lv});
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_request(cmd, lv, tg);
    pending_results.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  // Result side: random stalls, with long stretches of steady ready
  initial begin
    int lo;
    @(posedge clk_i iff rst_ni);
    forever begin
      lo = pick_gap();
      if (lo > 0) begin
        m_axis_tready <= 1'b0;
        repeat (lo) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 200)) @(posedge clk_i);
      else repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Check each result against the oldest expectation; watch for a hang
  always @(posedge clk_i) begin
    qresult_t exp_res;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(m_axis_tdata), 32'h0);
        end else begin
          exp_res = pending_results.pop_front();
          if (m_axis_tuser != exp_res.status)
            report_mismatch("status", 32'(m_axis_tuser), 32'(exp_res.status));
          if (m_axis_tdata[TAG_BITS-1:0] != exp_res.tag)
            report_mismatch("out_tag", 32'(m_axis_tdata[TAG_BITS-1:0]), 32'(exp_res.tag));
          if (m_axis_tdata[TAG_BITS +: LEVEL_BITS] != exp_res.level)
            report_mismatch("out_level", 32'(m_axis_tdata[TAG_BITS +: LEVEL_BITS]),
                            32'(exp_res.level));
          if (m_axis_tdata[TAG_BITS+LEVEL_BITS] != exp_res.empty)
            report_mismatch("is_empty", 32'(m_axis_tdata[TAG_BITS+LEVEL_BITS]),
                            32'(exp_res.empty));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Reset, directed table, random phases, drain and verdict
  initial begin
    int                    row;
    int                    k;
    int                    enq_pct;
    int                    lv_top;
    cmd_e                  cmd;
    logic [LEVEL_BITS-1:0] lv;
    logic [TAG_BITS-1:0]   tg;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < SCRIPT_ROWS; row++) begin
      for (k = 0; k < SCRIPT[row].reps; k++) begin
        lv = SCRIPT[row].level ^ LEVEL_BITS'(k);
        tg = SCRIPT[row].tag + TAG_BITS'(k);
        send_request(SCRIPT[row].cmd, lv, tg, SCRIPT[row].typed, SCRIPT[row].want);
      end
    end

    // Phases with their own enqueue mix, level spread and pacing
    while (sent_count < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0: enq_pct = 25;
        1: enq_pct = 50;
        2: enq_pct = 70;
        default: enq_pct = 90;
      endcase
      case ($urandom_range(0, 3))
        0: lv_top = 1;
        1: lv_top = 3;
        default: lv_top = (1 << LEVEL_BITS) - 1;
      endcase
      steady = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(20, 80)) begin
        cmd = ($urandom_range(1, 100) <= enq_pct) ? CMD_ENQ : CMD_DEQ;
        lv  = LEVEL_BITS'($urandom_range(0, lv_top));
        tg  = TAG_BITS'($urandom_range(0, (1 << TAG_BITS) - 1));
        send_request(cmd, lv, tg, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/spq_pkg.sv
sv/spq_ram.sv
sv/spq_ctrl.sv
sv/stable_priority_queue.sv
test/stable_priority_queue_tb.sv
